// File: rtl/hpp_pkg.sv
// shared types and constants of the heater pid power block
package hpp_pkg;

  localparam int NumElements = 256;
  localparam int AddrW       = $clog2(NumElements);
  localparam int MaxHeat     = 255;
  localparam int IdxW        = 8;
  localparam int TempW       = 16;
  localparam int GainW       = 16;
  localparam int DepthW      = 8;
  localparam int HeatW       = 8;
  localparam int DevW        = 15;
  localparam int ErrW        = 18;
  localparam int DerrW       = 19;
  localparam int StateW      = 2 * ErrW;
  localparam int NumW        = 27;
  localparam int DenW        = DepthW;
  localparam int DivStep     = 3;
  localparam int DivStages   = NumW / DivStep;
  localparam int ProdW       = DerrW + GainW + 1;
  localparam int SumW        = ProdW + 2;
  localparam int FracBits    = 12;
  localparam int HalfQ12     = 2048;
  localparam int CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegProp, RegInteg, RegDeriv, RegDepth, RegLimit, RegErrDev, RegSctDev
  } reg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0]         element_index;
    logic signed [TempW-1:0] heater_temp;
    logic                    heater_temp_valid;
    logic signed [TempW-1:0] setpoint_temp;
    logic                    element_ignored;
    logic                    has_schedule;
    logic                    last_panel;
    logic                    checks_disabled;
    logic [TempW-1:0]        neighbor_scatter;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0]  out_element;
    logic [HeatW-1:0] heat_power;
    logic             deviation_error;
    logic             scatter_error;
  } out_t;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic                    inrng;
    logic                    active;
    logic                    lastp;
    logic                    dev;
    logic                    sct;
    logic                    neg;
    logic signed [ErrW-1:0]  perr;
    logic signed [DerrW-1:0] derr;
  } ctx_t;

endpackage

// File: rtl/heater_pid_power.sv
// per-element pid heater power controller, top level
// an accepted input beat passes the input, error, divider stage, product and output registers in turn
// throughput: one beat per cycle for differing elements while the output is not stalled
// a beat for an element still in flight waits until its state is written back
// reset clears the control pipeline valid bits and the per-element valid flags and loads the registers' defaults
module heater_pid_power (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hpp_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hpp_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hpp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hpp_pkg::GainW-1:0]     cfg_data_i
);

  localparam int Last = hpp_pkg::DivStages - 1;

  logic [hpp_pkg::GainW-1:0]  prop_q, integ_q, deriv_q;
  logic [hpp_pkg::DepthW-1:0] depth_q;
  logic [hpp_pkg::HeatW-1:0]  limit_q;
  logic [hpp_pkg::DevW-1:0]   errdev_q, sctdev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q   <= hpp_pkg::GainW'(256);
      integ_q  <= '0;
      deriv_q  <= '0;
      depth_q  <= hpp_pkg::DepthW'(1);
      limit_q  <= '1;
      errdev_q <= '1;
      sctdev_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hpp_pkg::RegProp:   prop_q   <= cfg_data_i;
        hpp_pkg::RegInteg:  integ_q  <= cfg_data_i;
        hpp_pkg::RegDeriv:  deriv_q  <= cfg_data_i;
        hpp_pkg::RegDepth:  depth_q  <= cfg_data_i[hpp_pkg::DepthW-1:0];
        hpp_pkg::RegLimit:  limit_q  <= cfg_data_i[hpp_pkg::HeatW-1:0];
        hpp_pkg::RegErrDev: errdev_q <= cfg_data_i[hpp_pkg::DevW-1:0];
        hpp_pkg::RegSctDev: sctdev_q <= cfg_data_i[hpp_pkg::DevW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en, hazard, in_acc;
  logic v1_q, v2_q, v3_q, ov_q;
  logic vd_q [hpp_pkg::DivStages];
  hpp_pkg::in_t  in1_q;
  hpp_pkg::ctx_t ctx2_q, ctx3_q;
  hpp_pkg::ctx_t ctxd_q [hpp_pkg::DivStages];
  hpp_pkg::out_t out_q;

  assign en = !(ov_q && out_stall_i);

  always_comb begin
    hazard = (v1_q && in1_q.element_index == in_data_i.element_index)
          || (v2_q && ctx2_q.idx == in_data_i.element_index);
    for (int s = 0; s < hpp_pkg::DivStages; s++) begin
      if (vd_q[s] && ctxd_q[s].idx == in_data_i.element_index) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !en || hazard;
  assign in_acc     = in_valid_i && !in_stall_o;

  // element state store
  logic [hpp_pkg::AddrW-1:0]  raddr, waddr;
  logic [hpp_pkg::StateW-1:0] rdata, wdata;
  logic                       we;
  logic                       ent_vld_q [hpp_pkg::NumElements];
  logic                       ev1_q;

  assign raddr = hpp_pkg::AddrW'(in_data_i.element_index);

  hpp_ram #(
    .Width (hpp_pkg::StateW),
    .Depth (hpp_pkg::NumElements)
  ) u_state (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpp_pkg::NumElements; i++) begin
        ent_vld_q[i] <= 1'b0;
      end
      ev1_q <= 1'b0;
    end else begin
      if (we) begin
        ent_vld_q[waddr] <= 1'b1;
      end
      if (en) begin
        ev1_q <= ent_vld_q[raddr];
      end
    end
  end

  // error and integral numerator
  logic signed [hpp_pkg::ErrW-1:0]  rd_last, rd_int, perr, absp;
  logic signed [hpp_pkg::DerrW-1:0] derr;
  logic [hpp_pkg::DepthW-1:0]       depth, dm1;
  logic signed [hpp_pkg::NumW-1:0]  prod, num;
  logic [hpp_pkg::NumW-1:0]         mag;
  logic                             inrng, active, chk;
  hpp_pkg::ctx_t                    ctx_b;
  logic [hpp_pkg::NumW-1:0]         num2_q;
  logic [hpp_pkg::DenW-1:0]         den2_q;
  logic [hpp_pkg::NumW-1:0]         quo;

  always_comb begin
    rd_last = ev1_q ? $signed(rdata[hpp_pkg::StateW-1:hpp_pkg::ErrW]) : '0;
    rd_int  = ev1_q ? $signed(rdata[hpp_pkg::ErrW-1:0]) : '0;
    inrng   = 32'(in1_q.element_index) < 32'(hpp_pkg::NumElements);
    active  = inrng && in1_q.heater_temp_valid && !in1_q.element_ignored
           && in1_q.has_schedule;
    chk     = active && !in1_q.checks_disabled;
    perr    = hpp_pkg::ErrW'(in1_q.setpoint_temp) - hpp_pkg::ErrW'(in1_q.heater_temp);
    derr    = hpp_pkg::DerrW'(perr) - hpp_pkg::DerrW'(rd_last);
    depth   = (depth_q == '0) ? hpp_pkg::DepthW'(1) : depth_q;
    dm1     = depth - hpp_pkg::DepthW'(1);
    prod    = hpp_pkg::NumW'(rd_int) * hpp_pkg::NumW'($signed({1'b0, dm1}));
    num     = prod + hpp_pkg::NumW'(perr);
    mag     = num[hpp_pkg::NumW-1] ? hpp_pkg::NumW'(-num) : hpp_pkg::NumW'(num);
    absp    = perr[hpp_pkg::ErrW-1] ? -perr : perr;

    ctx_b.idx    = in1_q.element_index;
    ctx_b.inrng  = inrng;
    ctx_b.active = active;
    ctx_b.lastp  = in1_q.last_panel;
    ctx_b.dev    = chk && ($unsigned(absp) > hpp_pkg::ErrW'(errdev_q));
    ctx_b.sct    = chk && (in1_q.neighbor_scatter > hpp_pkg::TempW'(sctdev_q));
    ctx_b.neg    = num[hpp_pkg::NumW-1];
    ctx_b.perr   = perr;
    ctx_b.derr   = derr;
  end

  hpp_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num2_q),
    .den_i (den2_q),
    .quo_o (quo)
  );

  logic signed [hpp_pkg::ErrW-1:0] ierr;
  hpp_pkg::ctx_t                   ctxw;

  assign ctxw  = ctxd_q[Last];
  assign ierr  = ctxw.neg ? -$signed(hpp_pkg::ErrW'(quo)) : $signed(hpp_pkg::ErrW'(quo));
  assign we    = en && vd_q[Last] && ctxw.inrng;
  assign waddr = hpp_pkg::AddrW'(ctxw.idx);
  assign wdata = ctxw.active ? {ctxw.perr, ierr} : '0;

  // products and sum
  logic signed [hpp_pkg::ProdW-1:0] pp_q, pi_q, pd_q;
  logic signed [hpp_pkg::SumW-1:0]  sum;
  localparam int FracBitsW = hpp_pkg::FracBits;
  localparam int HW = hpp_pkg::SumW - FracBitsW;
  logic [HW-1:0]                    h;
  logic [hpp_pkg::HeatW-1:0]        lim, heat;

  always_comb begin
    sum = hpp_pkg::SumW'(pp_q) + hpp_pkg::SumW'(pi_q) + hpp_pkg::SumW'(pd_q)
        + hpp_pkg::SumW'(hpp_pkg::HalfQ12);
    h   = sum[hpp_pkg::SumW-1] ? '0 : sum[hpp_pkg::SumW-1:FracBitsW];
    lim = (32'(limit_q) > hpp_pkg::MaxHeat) ? hpp_pkg::HeatW'(hpp_pkg::MaxHeat) : limit_q;
    heat = (h > HW'(lim)) ? lim : h[hpp_pkg::HeatW-1:0];
    if (!ctx3_q.active || ctx3_q.lastp) begin
      heat = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
      for (int s = 0; s < hpp_pkg::DivStages; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_acc;
      v2_q    <= v1_q;
      vd_q[0] <= v2_q;
      for (int s = 1; s < hpp_pkg::DivStages; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
      v3_q <= vd_q[Last];
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q     <= in_data_i;
      ctx2_q    <= ctx_b;
      num2_q    <= mag;
      den2_q    <= depth;
      ctxd_q[0] <= ctx2_q;
      for (int s = 1; s < hpp_pkg::DivStages; s++) begin
        ctxd_q[s] <= ctxd_q[s-1];
      end
      ctx3_q <= ctxw;
      pp_q   <= hpp_pkg::ProdW'(ctxw.perr * $signed({1'b0, prop_q}));
      pi_q   <= hpp_pkg::ProdW'(ierr * $signed({1'b0, integ_q}));
      pd_q   <= hpp_pkg::ProdW'(ctxw.derr * $signed({1'b0, deriv_q}));
      out_q.out_element     <= ctx3_q.idx;
      out_q.heat_power      <= heat;
      out_q.deviation_error <= ctx3_q.dev;
      out_q.scatter_error   <= ctx3_q.sct;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/hpp_ram.sv
// generic single write port ram with registered read
module hpp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hpp_div.sv
// pipelined restoring divider, three quotient bits per stage
module hpp_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [hpp_pkg::NumW-1:0] num_i,
  input  logic [hpp_pkg::DenW-1:0] den_i,
  output logic [hpp_pkg::NumW-1:0] quo_o
);

  logic [hpp_pkg::DenW-1:0] r_q [hpp_pkg::DivStages];
  logic [hpp_pkg::NumW-1:0] n_q [hpp_pkg::DivStages];
  logic [hpp_pkg::DenW-1:0] d_q [hpp_pkg::DivStages];

  for (genvar s = 0; s < hpp_pkg::DivStages; s++) begin : g_stage
    logic [hpp_pkg::DenW-1:0] r_in, r_d, dv;
    logic [hpp_pkg::NumW-1:0] n_in, n_d;
    logic [hpp_pkg::DenW:0]   t;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num_i;
      assign dv   = den_i;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign n_in = n_q[s-1];
      assign dv   = d_q[s-1];
    end

    always_comb begin
      r_d = r_in;
      n_d = n_in;
      t   = '0;
      for (int k = 0; k < hpp_pkg::DivStep; k++) begin
        t = {r_d, n_d[hpp_pkg::NumW-1]};
        if (t >= {1'b0, dv}) begin
          r_d = hpp_pkg::DenW'(t - {1'b0, dv});
          n_d = {n_d[hpp_pkg::NumW-2:0], 1'b1};
        end else begin
          r_d = t[hpp_pkg::DenW-1:0];
          n_d = {n_d[hpp_pkg::NumW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_d;
        n_q[s] <= n_d;
        d_q[s] <= dv;
      end
    end
  end

  assign quo_o = n_q[hpp_pkg::DivStages-1];

endmodule

// File: rtl/hpp_chk.sv
// port checker for heater_pid_power and its bind
module hpp_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input hpp_pkg::out_t               out_data_o,
  input logic                        cfg_we_i,
  input logic [hpp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [hpp_pkg::GainW-1:0]   cfg_data_i
);

  logic [hpp_pkg::HeatW-1:0] lim_q;
  logic [4:0]                cnt_q, cnt_d;
  logic                      in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cnt_d   = cnt_q + 5'(in_acc) - 5'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '1;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i && cfg_idx_i == hpp_pkg::RegLimit) begin
        lim_q <= cfg_data_i[hpp_pkg::HeatW-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.heat_power <= lim_q)
    else $error("heat power above configured limit");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result beat without an outstanding input beat");

endmodule

bind heater_pid_power hpp_chk u_hpp_chk (.*);
